// ===== sv/rcpls_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpls_pkg: shared types and constants of the RC pulse light sequencer
// Register map, reset values, configuration and result bundles.
// ----------------------------------------------------------------------------
package rcpls_pkg;

   // field widths
   localparam int unsigned WidthW    = 16;
   localparam int unsigned LevelW    = 8;
   localparam int unsigned FadeTimeW = 20;
   localparam int unsigned StrobeW   = 22;
   localparam int unsigned FlashW    = 20;

   // register port geometry
   localparam int unsigned CsrAddrW  = 5;
   localparam int unsigned CsrDataW  = 32;

   // register reset values
   localparam logic [WidthW-1:0]    LowThresholdReset   = 16'd1000;
   localparam logic [WidthW-1:0]    HighThresholdReset  = 16'd1800;
   localparam logic [LevelW-1:0]    FadeMinReset        = 8'd10;
   localparam logic [LevelW-1:0]    FadeMaxReset        = 8'd75;
   localparam logic [FadeTimeW-1:0] FadeIntervalReset   = 20'd25000;
   localparam logic [StrobeW-1:0]   StrobeIntervalReset = 22'd2000000;
   localparam logic [FlashW-1:0]    FlashTimeReset      = 20'd50000;

   // full beacon level during a flash
   localparam logic [LevelW-1:0]    LevelFull           = 8'd255;

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_LOW_THRESHOLD   = 3'd0,
      REG_HIGH_THRESHOLD  = 3'd1,
      REG_FADE_MIN        = 3'd2,
      REG_FADE_MAX        = 3'd3,
      REG_FADE_INTERVAL   = 3'd4,
      REG_STROBE_INTERVAL = 3'd5,
      REG_FLASH_TIME      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [WidthW-1:0]    low_threshold;
      logic [WidthW-1:0]    high_threshold;
      logic [LevelW-1:0]    fade_min;
      logic [LevelW-1:0]    fade_max;
      logic [FadeTimeW-1:0] fade_interval;
      logic [StrobeW-1:0]   strobe_interval;
      logic [FlashW-1:0]    flash_time;
   } cfg_type;

   // result beat, nav_on in the lowest bit
   typedef struct packed {
      logic [WidthW-1:0] pulse_width;
      logic [LevelW-1:0] beacon_two_level;
      logic [LevelW-1:0] beacon_one_level;
      logic              strobe_on;
      logic              landing_on;
      logic              nav_on;
   } rsp_type;

   localparam int unsigned RspW     = $bits(rsp_type);
   localparam int unsigned RspBytes = (RspW + 7) / 8;

endpackage

// ===== sv/rcpls_csr.sv =====
// ----------------------------------------------------------------------------
// rcpls_csr: configuration register file
// APB-style write and read of the seven sequencer settings.
// ----------------------------------------------------------------------------
module rcpls_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rcpls_pkg::CsrAddrW-1:0]    csr_paddr,
   input  logic [rcpls_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [rcpls_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                              csr_pready,
   output rcpls_pkg::cfg_type                cfg
);

   rcpls_pkg::cfg_type cfg_ff;
   logic               wr_en;
   logic [2:0]         reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // write the addressed register, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold   <= rcpls_pkg::LowThresholdReset;
         cfg_ff.high_threshold  <= rcpls_pkg::HighThresholdReset;
         cfg_ff.fade_min        <= rcpls_pkg::FadeMinReset;
         cfg_ff.fade_max        <= rcpls_pkg::FadeMaxReset;
         cfg_ff.fade_interval   <= rcpls_pkg::FadeIntervalReset;
         cfg_ff.strobe_interval <= rcpls_pkg::StrobeIntervalReset;
         cfg_ff.flash_time      <= rcpls_pkg::FlashTimeReset;
      end else if (wr_en) begin
         case (reg_index)
            rcpls_pkg::REG_LOW_THRESHOLD: begin
               cfg_ff.low_threshold <= csr_pwdata[rcpls_pkg::WidthW-1:0];
            end
            rcpls_pkg::REG_HIGH_THRESHOLD: begin
               cfg_ff.high_threshold <= csr_pwdata[rcpls_pkg::WidthW-1:0];
            end
            rcpls_pkg::REG_FADE_MIN: begin
               cfg_ff.fade_min <= csr_pwdata[rcpls_pkg::LevelW-1:0];
            end
            rcpls_pkg::REG_FADE_MAX: begin
               cfg_ff.fade_max <= csr_pwdata[rcpls_pkg::LevelW-1:0];
            end
            rcpls_pkg::REG_FADE_INTERVAL: begin
               cfg_ff.fade_interval <= csr_pwdata[rcpls_pkg::FadeTimeW-1:0];
            end
            rcpls_pkg::REG_STROBE_INTERVAL: begin
               cfg_ff.strobe_interval <= csr_pwdata[rcpls_pkg::StrobeW-1:0];
            end
            rcpls_pkg::REG_FLASH_TIME: begin
               cfg_ff.flash_time <= csr_pwdata[rcpls_pkg::FlashW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read back, zero-extended
   always_comb begin
      case (reg_index)
         rcpls_pkg::REG_LOW_THRESHOLD:
            csr_prdata = {16'd0, cfg_ff.low_threshold};
         rcpls_pkg::REG_HIGH_THRESHOLD:
            csr_prdata = {16'd0, cfg_ff.high_threshold};
         rcpls_pkg::REG_FADE_MIN:
            csr_prdata = {24'd0, cfg_ff.fade_min};
         rcpls_pkg::REG_FADE_MAX:
            csr_prdata = {24'd0, cfg_ff.fade_max};
         rcpls_pkg::REG_FADE_INTERVAL:
            csr_prdata = {12'd0, cfg_ff.fade_interval};
         rcpls_pkg::REG_STROBE_INTERVAL:
            csr_prdata = {10'd0, cfg_ff.strobe_interval};
         rcpls_pkg::REG_FLASH_TIME:
            csr_prdata = {12'd0, cfg_ff.flash_time};
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

// ===== sv/rcpls_step.sv =====
// ----------------------------------------------------------------------------
// rcpls_step: per-tick sequencer state and next-state logic
// Pulse measurement, fade triangle, beacon flash and strobe burst timers.
// ----------------------------------------------------------------------------
module rcpls_step (
   input  logic               clock,
   input  logic               reset,
   input  rcpls_pkg::cfg_type cfg,
   input  logic               tick,
   input  logic               rc_level,
   output rcpls_pkg::rsp_type result
);

   localparam logic [1:0] StrobeIdle = 2'd0;
   localparam logic [1:0] StrobeOne  = 2'd1;
   localparam logic [1:0] StrobeTwo  = 2'd3;

   // state
   logic                               prev_level_ff, prev_level_in;
   logic [rcpls_pkg::WidthW-1:0]       pulse_count_ff, pulse_count_in;
   logic [rcpls_pkg::WidthW-1:0]       latched_width_ff, latched_width_in;
   logic [rcpls_pkg::LevelW-1:0]       fade_level_ff, fade_level_in;
   logic                               fade_rising_ff, fade_rising_in;
   logic [rcpls_pkg::FadeTimeW-1:0]    fade_elapsed_ff, fade_elapsed_in;
   logic [rcpls_pkg::StrobeW-1:0]      strobe_elapsed_ff, strobe_elapsed_in;
   logic [rcpls_pkg::FlashW-1:0]       flash_timer_ff, flash_timer_in;
   logic                               flash_which_ff, flash_which_in;
   logic [1:0]                         strobe_phase_ff, strobe_phase_in;
   logic [rcpls_pkg::FlashW-1:0]       phase_timer_ff, phase_timer_in;

   // intermediates
   logic                               switch_on;
   logic                               landing;
   logic                               fade_step;
   logic                               fade_end;
   logic [rcpls_pkg::LevelW-1:0]       fade_next;
   logic [1:0]                         phase_next;
   logic [rcpls_pkg::LevelW-1:0]       beacon_one;
   logic [rcpls_pkg::LevelW-1:0]       beacon_two;

   always_comb begin
      // measure the high pulse, latch on the falling edge
      pulse_count_in   = pulse_count_ff;
      latched_width_in = latched_width_ff;
      if (rc_level) begin
         if (!prev_level_ff) begin
            pulse_count_in = 16'd1;
         end else if (pulse_count_ff != '1) begin
            pulse_count_in = pulse_count_ff + 16'd1;
         end
      end else if (prev_level_ff) begin
         latched_width_in = pulse_count_ff;
      end
      prev_level_in = rc_level;

      // free-running elapsed counters, saturating
      fade_elapsed_in   = (fade_elapsed_ff == '1) ? fade_elapsed_ff
                                                  : fade_elapsed_ff + 20'd1;
      strobe_elapsed_in = (strobe_elapsed_ff == '1) ? strobe_elapsed_ff
                                                    : strobe_elapsed_ff + 22'd1;

      switch_on = latched_width_in > cfg.low_threshold;
      landing   = switch_on && (latched_width_in > cfg.high_threshold);

      fade_level_in   = fade_level_ff;
      fade_rising_in  = fade_rising_ff;
      flash_which_in  = flash_which_ff;
      flash_timer_in  = '0;
      strobe_phase_in = StrobeIdle;
      phase_timer_in  = '0;
      fade_step       = 1'b0;
      fade_next       = fade_rising_ff ? fade_level_ff + 8'd1 : fade_level_ff - 8'd1;
      fade_end        = (fade_next == cfg.fade_max) || (fade_next == cfg.fade_min);
      phase_next      = strobe_phase_ff + 2'd1;

      if (switch_on) begin
         // count the beacon flash down
         flash_timer_in = (flash_timer_ff != '0) ? flash_timer_ff - 20'd1 : '0;

         // step the fade, flash and turn at either end
         fade_step = (fade_elapsed_in > cfg.fade_interval) && (flash_timer_in == '0);
         if (fade_step) begin
            fade_level_in = fade_next;
            if (fade_end) begin
               flash_which_in = !fade_rising_ff;
               flash_timer_in = cfg.flash_time;
               fade_rising_in = !fade_rising_ff;
            end
            fade_elapsed_in = '0;
         end

         // sequence the strobe burst
         strobe_phase_in = strobe_phase_ff;
         phase_timer_in  = phase_timer_ff;
         if (strobe_phase_ff != StrobeIdle) begin
            if (phase_timer_ff > 20'd1) begin
               phase_timer_in = phase_timer_ff - 20'd1;
            end else begin
               strobe_phase_in = phase_next;
               phase_timer_in  = (phase_next != StrobeIdle) ? cfg.flash_time : '0;
            end
         end else if (strobe_elapsed_in > cfg.strobe_interval) begin
            strobe_phase_in   = StrobeOne;
            phase_timer_in    = cfg.flash_time;
            strobe_elapsed_in = '0;
         end
      end

      // beacon levels, full on the flashing one
      beacon_one = fade_level_in;
      beacon_two = cfg.fade_max - fade_level_in + cfg.fade_min;
      if (flash_timer_in != '0) begin
         if (flash_which_in) begin
            beacon_two = rcpls_pkg::LevelFull;
         end else begin
            beacon_one = rcpls_pkg::LevelFull;
         end
      end

      result.nav_on           = switch_on;
      result.landing_on       = landing;
      result.strobe_on        = switch_on && ((strobe_phase_in == StrobeOne) ||
                                              (strobe_phase_in == StrobeTwo));
      result.beacon_one_level = switch_on ? beacon_one : '0;
      result.beacon_two_level = switch_on ? beacon_two : '0;
      result.pulse_width      = latched_width_in;
   end

   // advance the state on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff     <= 1'b0;
         pulse_count_ff    <= '0;
         latched_width_ff  <= '0;
         fade_level_ff     <= rcpls_pkg::FadeMinReset;
         fade_rising_ff    <= 1'b1;
         fade_elapsed_ff   <= '0;
         strobe_elapsed_ff <= '0;
         flash_timer_ff    <= '0;
         flash_which_ff    <= 1'b0;
         strobe_phase_ff   <= StrobeIdle;
         phase_timer_ff    <= '0;
      end else if (tick) begin
         prev_level_ff     <= prev_level_in;
         pulse_count_ff    <= pulse_count_in;
         latched_width_ff  <= latched_width_in;
         fade_level_ff     <= fade_level_in;
         fade_rising_ff    <= fade_rising_in;
         fade_elapsed_ff   <= fade_elapsed_in;
         strobe_elapsed_ff <= strobe_elapsed_in;
         flash_timer_ff    <= flash_timer_in;
         flash_which_ff    <= flash_which_in;
         strobe_phase_ff   <= strobe_phase_in;
         phase_timer_ff    <= phase_timer_in;
      end
   end

endmodule

// ===== sv/rc_pulse_light_sequencer.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_light_sequencer: RC-controlled navigation, landing, beacon, strobe
// A result beat appears on rsp_ in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless rsp_ stalls; tick logic is one pass
// from state to the output register; req_tready stays high while it drains.
// Reset (synchronous): state to its idle values, registers to their defaults,
// output register empty; no tick is taken while reset is high.
// ----------------------------------------------------------------------------
module rc_pulse_light_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   // input ticks
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [0] rc_level
   // result beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] nav_on, [1] landing_on, [2] strobe_on, [10:3] beacon_one_level,
   // [18:11] beacon_two_level, [34:19] pulse_width, [39:35] zero
   output logic [rcpls_pkg::RspBytes*8-1:0]     rsp_tdata,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rcpls_pkg::CsrAddrW-1:0]       csr_paddr,
   input  logic [rcpls_pkg::CsrDataW-1:0]       csr_pwdata,
   output logic [rcpls_pkg::CsrDataW-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   rcpls_pkg::cfg_type cfg;
   rcpls_pkg::rsp_type result;
   rcpls_pkg::rsp_type rsp_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   rcpls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rcpls_step u_step (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .tick     (accept),
      .rc_level (req_tdata[0]),
      .result   (result)
   );

   // take a tick whenever the output register is empty or draining
   assign req_tready   = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the beat until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rcpls_pkg::RspBytes*8-rcpls_pkg::RspW){1'b0}}, rsp_data_ff};

endmodule

// ===== sv/rcpls_checker.sv =====
// ----------------------------------------------------------------------------
// rcpls_checker: port-level checks of the light sequencer
// Handshake behaviour and consistency of the light drives on each beat.
// ----------------------------------------------------------------------------
module rcpls_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // every accepted tick shows a beat in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick gave no result beat");

   // an empty output register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // lights off darkens landing, strobe and both beacons
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[18:1] == 18'd0)
      else $error("light driven while switched off");

   // landing light only with navigation lights
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("landing light without navigation lights");

endmodule

bind rc_pulse_light_sequencer rcpls_checker u_rcpls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
